>>> rtl/core/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// shared types, codes and sizes of the generational handle table
// ----------------------------------------------------------------------------
package ght_pkg;

	localparam int SLOT_COUNT = 256;
	localparam int IDX_W      = $clog2(SLOT_COUNT);
	localparam int CNT_W      = $clog2(SLOT_COUNT) + 1;
	localparam int GEN_W      = 32;
	localparam int REF_W      = 16;
	localparam int WORD_W     = 32;

	// operation codes
	localparam logic [2:0] MODE_BOX     = 3'd0;
	localparam logic [2:0] MODE_SPHERE  = 3'd1;
	localparam logic [2:0] MODE_ADD     = 3'd2;
	localparam logic [2:0] MODE_RELEASE = 3'd3;
	localparam logic [2:0] MODE_DESTROY = 3'd4;

	// result status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_ZERO    = 2'd3;

	typedef struct packed {
		logic [2:0]             mode;
		logic [IDX_W-1:0]       slot_index;
		logic [GEN_W-1:0]       slot_generation;
		logic [2:0][WORD_W-1:0] offset;
		logic [2:0][WORD_W-1:0] extent;
		logic [WORD_W-1:0]      sphere_radius;
	} in_item_t;

	typedef struct packed {
		logic                   kind;
		logic [2:0][WORD_W-1:0] offset;
		logic [2:0][WORD_W-1:0] extent;
		logic [WORD_W-1:0]      radius;
	} record_t;

	typedef struct packed {
		logic [IDX_W-1:0] owner;
		record_t          rec;
	} dense_entry_t;

	typedef struct packed {
		logic [REF_W-1:0] refs;
		logic [GEN_W-1:0] gen;
	} slot_info_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] index;
		logic [GEN_W-1:0] generation;
		logic [REF_W-1:0] ref_count;
		logic             destroyed;
		logic [CNT_W-1:0] live_count;
	} result_t;

	// datapath commands
	typedef enum logic [3:0] {
		DP_NOP,
		DP_CAPTURE,
		DP_FULL,
		DP_INVALID,
		DP_CR_FRESH,
		DP_RD_FREE,
		DP_CR_RD_SLOT,
		DP_CR_REUSE,
		DP_REF_RD,
		DP_REF_RD_DENSE,
		DP_ADDREF,
		DP_ZERO,
		DP_DEC,
		DP_KILL,
		DP_RD_LAST,
		DP_MOVE
	} dp_op_t;

	typedef struct packed {
		logic is_create;
		logic is_unknown;
		logic is_add;
		logic is_release;
		logic has_free;
		logic issued_full;
		logic valid;
		logic refs_zero;
		logic refs_one;
		logic at_last;
		logic out_free;
	} dp_status_t;

endpackage

>>> rtl/core/ght_in_if.sv
// ----------------------------------------------------------------------------
// ght_in_if
// request channel of the handle table
// ----------------------------------------------------------------------------
interface ght_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [7:0]  slot_index;
	logic [31:0] slot_generation;
	logic [31:0] offset_x;
	logic [31:0] offset_y;
	logic [31:0] offset_z;
	logic [31:0] extent_x;
	logic [31:0] extent_y;
	logic [31:0] extent_z;
	logic [31:0] sphere_radius;

	modport source (
		output valid, mode, slot_index, slot_generation, offset_x, offset_y, offset_z,
		output extent_x, extent_y, extent_z, sphere_radius,
		input  ready
	);
	modport sink (
		input  valid, mode, slot_index, slot_generation, offset_x, offset_y, offset_z,
		input  extent_x, extent_y, extent_z, sphere_radius,
		output ready
	);
endinterface

>>> rtl/core/ght_out_if.sv
// ----------------------------------------------------------------------------
// ght_out_if
// response channel of the handle table
// ----------------------------------------------------------------------------
interface ght_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  out_index;
	logic [31:0] out_generation;
	logic [15:0] ref_count;
	logic        destroyed;
	logic [8:0]  live_count;

	modport source (
		output valid, status, out_index, out_generation, ref_count, destroyed, live_count,
		input  ready
	);
	modport sink (
		input  valid, status, out_index, out_generation, ref_count, destroyed, live_count,
		output ready
	);
endinterface

>>> rtl/core/generational_handle_table.sv
// ----------------------------------------------------------------------------
// generational_handle_table
// slot map of box and sphere records with generation checked handles
// ----------------------------------------------------------------------------
//  channel  | dir | transaction
//  ---------+-----+-------------------------------------------------------
//  in_ch    | in  | mode, handle (index, generation), shape payload words
//  out_ch   | out | status, index, generation, ref count, destroyed, live
//
//  one transaction at a time; after the accepting idle step, a create on
//  a fresh slot, table full and unknown mode go dispatch, emit; create on
//  a reused slot goes dispatch, slot read, commit, emit; ref ops and
//  destroy of the last record go dispatch, dense read, evaluate, emit;
//  destroy that moves the last record adds a move step before emit; the
//  dependent sparse map, slot info and dense owner reads set the steps
//  counters and handshake state clear on arst_n, stores need no clearing
//  a response waiting on out_ch does not block the next accept; the
//  sequencer holds in its emit step only until the output register frees
// ----------------------------------------------------------------------------
module generational_handle_table
	import ght_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	ght_in_if.sink    in_ch,
	ght_out_if.source out_ch
);
	dp_op_t     op;
	dp_status_t stat;
	in_item_t   item;
	result_t    res;
	logic       in_ready;
	logic       res_valid;

	// request payload packed for the datapath
	assign item.mode            = in_ch.mode;
	assign item.slot_index      = in_ch.slot_index;
	assign item.slot_generation = in_ch.slot_generation;
	assign item.offset          = {in_ch.offset_z, in_ch.offset_y, in_ch.offset_x};
	assign item.extent          = {in_ch.extent_z, in_ch.extent_y, in_ch.extent_x};
	assign item.sphere_radius   = in_ch.sphere_radius;

	assign in_ch.ready = in_ready;

	// sequencer
	ght_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.op       (op)
	);

	// stores, counters and response register; emit loads the response
	// only in the sequencer's emit step, the one busy step without a command
	ght_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.item      (item),
		.stat      (stat),
		.out_res   (res),
		.out_valid (res_valid),
		.out_ready (out_ch.ready),
		.emit      (op == DP_NOP && !in_ready && stat.out_free)
	);

	assign out_ch.valid          = res_valid;
	assign out_ch.status         = res.status;
	assign out_ch.out_index      = res.index;
	assign out_ch.out_generation = res.generation;
	assign out_ch.ref_count      = res.ref_count;
	assign out_ch.destroyed      = res.destroyed;
	assign out_ch.live_count     = res.live_count;
endmodule

>>> rtl/core/ght_ram.sv
// ----------------------------------------------------------------------------
// ght_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ght_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;
endmodule

>>> rtl/core/ght_ctrl.sv
// ----------------------------------------------------------------------------
// ght_ctrl
// sequencer that steps the datapath through one transaction at a time
// ----------------------------------------------------------------------------
module ght_ctrl
	import ght_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t stat,
	output dp_op_t     op
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_CR_SLOT,
		S_CR_COMMIT,
		S_REF_DENSE,
		S_REF_EVAL,
		S_MOVE,
		S_EMIT
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		op      = DP_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op      = DP_CAPTURE;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.is_create) begin
					if (stat.has_free) begin
						op      = DP_RD_FREE;
						state_d = S_CR_SLOT;
					end else if (stat.issued_full) begin
						op      = DP_FULL;
						state_d = S_EMIT;
					end else begin
						op      = DP_CR_FRESH;
						state_d = S_EMIT;
					end
				end else if (stat.is_unknown) begin
					op      = DP_INVALID;
					state_d = S_EMIT;
				end else begin
					op      = DP_REF_RD;
					state_d = S_REF_DENSE;
				end
			end
			S_CR_SLOT: begin
				op      = DP_CR_RD_SLOT;
				state_d = S_CR_COMMIT;
			end
			S_CR_COMMIT: begin
				op      = DP_CR_REUSE;
				state_d = S_EMIT;
			end
			S_REF_DENSE: begin
				op      = DP_REF_RD_DENSE;
				state_d = S_REF_EVAL;
			end
			S_REF_EVAL: begin
				state_d = S_EMIT;
				if (!stat.valid) begin
					op = DP_INVALID;
				end else if (stat.is_add) begin
					op = DP_ADDREF;
				end else if (stat.is_release && stat.refs_zero) begin
					op = DP_ZERO;
				end else if (stat.is_release && !stat.refs_one) begin
					op = DP_DEC;
				end else if (stat.at_last) begin
					op = DP_KILL;
				end else begin
					op      = DP_RD_LAST;
					state_d = S_MOVE;
				end
			end
			S_MOVE: begin
				op      = DP_MOVE;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);
endmodule

>>> rtl/core/ght_dp.sv
// ----------------------------------------------------------------------------
// ght_dp
// handle table datapath: slot, dense and free stores, counters, result
// ----------------------------------------------------------------------------
module ght_dp
	import ght_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  dp_op_t     op,
	input  in_item_t   item,
	output dp_status_t stat,
	output result_t    out_res,
	output logic       out_valid,
	input  logic       out_ready,
	input  logic       emit
);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOT_COUNT);

	// counters
	logic [CNT_W-1:0] free_top_q, issued_q, dense_cnt_q;
	logic             out_valid_q;

	// transaction registers
	logic [2:0]       mode_q;
	logic [IDX_W-1:0] idx_q, slot_q, dpos_q;
	logic [GEN_W-1:0] gen_in_q, gen_q;
	logic [REF_W-1:0] refs_q;
	record_t          rec_q;
	result_t          res_q, out_q;

	// ram ports
	logic             sp_we, info_we, dn_we, fr_we;
	logic [IDX_W-1:0] sp_wa, info_wa, dn_wa, fr_wa;
	logic [IDX_W-1:0] sp_wd, fr_wd;
	slot_info_t       info_wd, info_rd;
	dense_entry_t     dn_wd, dn_rd;
	logic [IDX_W-1:0] sp_rd, fr_rd;
	logic [IDX_W-1:0] info_ra, dn_ra, fr_ra;

	logic [CNT_W-1:0] dc_m1, dc_p1, ft_m1;
	logic [IDX_W-1:0] last_pos;
	logic [REF_W-1:0] refs_sat, refs_dec;
	logic [GEN_W-1:0] gen_bump, reuse_gen;
	logic             sphere;
	logic             is_kill;

	assign dc_m1     = dense_cnt_q - CNT_W'(1);
	assign dc_p1     = dense_cnt_q + CNT_W'(1);
	assign ft_m1     = free_top_q - CNT_W'(1);
	assign last_pos  = dc_m1[IDX_W-1:0];
	assign refs_sat  = (refs_q == {REF_W{1'b1}}) ? refs_q : refs_q + REF_W'(1);
	assign refs_dec  = refs_q - REF_W'(1);
	assign gen_bump  = gen_q + GEN_W'(1);
	assign reuse_gen = info_rd.gen + GEN_W'(1);
	assign sphere    = (item.mode == MODE_SPHERE);
	assign is_kill   = (op == DP_KILL) || (op == DP_MOVE);

	// status toward the sequencer
	always_comb begin
		stat.is_create   = (mode_q == MODE_BOX) || (mode_q == MODE_SPHERE);
		stat.is_unknown  = (mode_q > MODE_DESTROY);
		stat.is_add      = (mode_q == MODE_ADD);
		stat.is_release  = (mode_q == MODE_RELEASE);
		stat.has_free    = (free_top_q != '0);
		stat.issued_full = (issued_q == FULL_CNT);
		stat.valid       = ({1'b0, idx_q} < issued_q) && ({1'b0, dpos_q} < dense_cnt_q)
			&& (dn_rd.owner == idx_q) && (gen_q == gen_in_q);
		stat.refs_zero   = (refs_q == '0);
		stat.refs_one    = (refs_q == REF_W'(1));
		stat.at_last     = (dpos_q == last_pos);
		stat.out_free    = !out_valid_q;
	end

	// read addresses
	assign fr_ra   = ft_m1[IDX_W-1:0];
	assign info_ra = (op == DP_CR_RD_SLOT) ? fr_rd : idx_q;
	assign dn_ra   = (op == DP_RD_LAST) ? last_pos : sp_rd;

	// writes
	always_comb begin
		sp_we   = 1'b0;
		sp_wa   = idx_q;
		sp_wd   = dense_cnt_q[IDX_W-1:0];
		info_we = 1'b0;
		info_wa = idx_q;
		info_wd = '{refs: '0, gen: gen_bump};
		dn_we   = 1'b0;
		dn_wa   = dense_cnt_q[IDX_W-1:0];
		dn_wd   = '{owner: issued_q[IDX_W-1:0], rec: rec_q};
		fr_we   = 1'b0;
		fr_wa   = free_top_q[IDX_W-1:0];
		fr_wd   = idx_q;
		case (op)
			DP_CR_FRESH, DP_CR_REUSE: begin
				sp_we   = 1'b1;
				info_we = 1'b1;
				dn_we   = 1'b1;
				if (op == DP_CR_FRESH) begin
					sp_wa   = issued_q[IDX_W-1:0];
					info_wa = issued_q[IDX_W-1:0];
					info_wd = '{refs: '0, gen: '0};
				end else begin
					sp_wa   = slot_q;
					info_wa = slot_q;
					info_wd = '{refs: '0, gen: reuse_gen};
					dn_wd   = '{owner: slot_q, rec: rec_q};
				end
			end
			DP_ADDREF: begin
				info_we = 1'b1;
				info_wd = '{refs: refs_sat, gen: gen_q};
			end
			DP_DEC: begin
				info_we = 1'b1;
				info_wd = '{refs: refs_dec, gen: gen_q};
			end
			DP_KILL, DP_MOVE: begin
				info_we = 1'b1;
				fr_we   = 1'b1;
				if (op == DP_MOVE) begin
					// last record fills the hole, back maps follow
					dn_we = 1'b1;
					dn_wa = dpos_q;
					dn_wd = dn_rd;
					sp_we = 1'b1;
					sp_wa = dn_rd.owner;
					sp_wd = dpos_q;
				end
			end
			default: begin
			end
		endcase
	end

	ght_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_sparse (
		.clk(clk), .wr_en(sp_we), .wr_addr(sp_wa), .wr_data(sp_wd),
		.rd_addr(idx_q), .rd_data(sp_rd)
	);
	ght_ram #(.WIDTH($bits(slot_info_t)), .DEPTH(SLOT_COUNT)) u_info (
		.clk(clk), .wr_en(info_we), .wr_addr(info_wa), .wr_data(info_wd),
		.rd_addr(info_ra), .rd_data(info_rd)
	);
	ght_ram #(.WIDTH($bits(dense_entry_t)), .DEPTH(SLOT_COUNT)) u_dense (
		.clk(clk), .wr_en(dn_we), .wr_addr(dn_wa), .wr_data(dn_wd),
		.rd_addr(dn_ra), .rd_data(dn_rd)
	);
	ght_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_free (
		.clk(clk), .wr_en(fr_we), .wr_addr(fr_wa), .wr_data(fr_wd),
		.rd_addr(fr_ra), .rd_data(fr_rd)
	);

	// counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_top_q  <= '0;
			issued_q    <= '0;
			dense_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (op)
				DP_CR_FRESH: begin
					issued_q    <= issued_q + CNT_W'(1);
					dense_cnt_q <= dc_p1;
				end
				DP_RD_FREE: begin
					free_top_q <= ft_m1;
				end
				DP_CR_REUSE: begin
					dense_cnt_q <= dc_p1;
				end
				DP_KILL, DP_MOVE: begin
					free_top_q  <= free_top_q + CNT_W'(1);
					dense_cnt_q <= dc_m1;
				end
				default: begin
				end
			endcase
			if (emit && !out_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// transaction payload
	always_ff @(posedge clk) begin
		if (op == DP_CAPTURE) begin
			mode_q       <= item.mode;
			idx_q        <= item.slot_index;
			gen_in_q     <= item.slot_generation;
			rec_q.kind   <= sphere;
			rec_q.offset <= item.offset;
			rec_q.extent <= sphere ? '0 : item.extent;
			rec_q.radius <= sphere ? item.sphere_radius : '0;
		end
		if (op == DP_CR_RD_SLOT) begin
			slot_q <= fr_rd;
		end
		if (op == DP_REF_RD_DENSE) begin
			dpos_q <= sp_rd;
			gen_q  <= info_rd.gen;
			refs_q <= info_rd.refs;
		end
		case (op)
			DP_FULL:     res_q <= '{ST_FULL, '0, '0, '0, 1'b0, dense_cnt_q};
			DP_INVALID:  res_q <= '{ST_INVALID, idx_q, '0, '0, 1'b0, dense_cnt_q};
			DP_CR_FRESH: res_q <= '{ST_DONE, issued_q[IDX_W-1:0], '0, '0, 1'b0, dc_p1};
			DP_CR_REUSE: res_q <= '{ST_DONE, slot_q, reuse_gen, '0, 1'b0, dc_p1};
			DP_ADDREF:   res_q <= '{ST_DONE, idx_q, gen_q, refs_sat, 1'b0, dense_cnt_q};
			DP_ZERO:     res_q <= '{ST_ZERO, idx_q, gen_q, '0, 1'b0, dense_cnt_q};
			DP_DEC:      res_q <= '{ST_DONE, idx_q, gen_q, refs_dec, 1'b0, dense_cnt_q};
			default: begin
				if (is_kill) begin
					res_q <= '{ST_DONE, idx_q, gen_bump, '0, 1'b1, dc_m1};
				end
			end
		endcase
		if (emit && !out_valid_q) begin
			out_q <= res_q;
		end
	end

	assign out_res   = out_q;
	assign out_valid = out_valid_q;
endmodule

>>> verif/ght_checker.sv
// ----------------------------------------------------------------------------
// ght_checker
// watches both channels of the handle table, predicts each response from
// the accepted requests with its own slot map, and counts mismatches
// ----------------------------------------------------------------------------
module ght_checker
	import ght_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	ght_in_if     in_ch,
	ght_out_if    out_ch,
	output int    err_count,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow slot map
	logic [IDX_W-1:0] sp_map  [SLOT_COUNT];
	logic [IDX_W-1:0] owner   [SLOT_COUNT];
	logic [REF_W-1:0] refs    [SLOT_COUNT];
	logic [GEN_W-1:0] gens    [SLOT_COUNT];
	logic [IDX_W-1:0] free_st [SLOT_COUNT];
	int               free_top, issued, live;
	result_t          resp_q[$];

	function automatic bit handle_ok(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] g);
		if (idx >= issued) return 0;
		if (sp_map[idx] >= live) return 0;
		return owner[sp_map[idx]] == idx && gens[idx] == g;
	endfunction

	// remove a live slot: last record fills the hole
	task automatic kill_slot(logic [IDX_W-1:0] idx);
		int d, last;
		d = sp_map[idx];
		last = live - 1;
		if (d != last) begin
			sp_map[owner[last]] = IDX_W'(d);
			owner[d] = owner[last];
		end
		live = last;
		refs[idx] = 0;
		gens[idx] = gens[idx] + 1;
		free_st[free_top] = idx;
		free_top++;
	endtask

	task automatic predict_op(logic [2:0] m, logic [IDX_W-1:0] idx, logic [GEN_W-1:0] g);
		result_t r;
		int s;
		r = '0;
		if (m == MODE_BOX || m == MODE_SPHERE) begin
			if (free_top > 0) begin
				free_top--;
				s = free_st[free_top];
				gens[s] = gens[s] + 1;
			end else if (issued < SLOT_COUNT) begin
				s = issued;
				issued++;
				gens[s] = 0;
			end else begin
				s = -1;
			end
			if (s < 0) begin
				r.status = ST_FULL;
			end else begin
				sp_map[s] = IDX_W'(live);
				owner[live] = IDX_W'(s);
				refs[s] = 0;
				live++;
				r.status = ST_DONE;
				r.index = IDX_W'(s);
				r.generation = gens[s];
			end
		end else if (m > MODE_DESTROY || !handle_ok(idx, g)) begin
			r.status = ST_INVALID;
			r.index = idx;
		end else begin
			r.index = idx;
			r.status = ST_DONE;
			if (m == MODE_ADD) begin
				if (refs[idx] != '1) refs[idx]++;
				r.ref_count = refs[idx];
			end else if (m == MODE_RELEASE && refs[idx] == 0) begin
				r.status = ST_ZERO;
			end else if (m == MODE_RELEASE && refs[idx] > 1) begin
				refs[idx]--;
				r.ref_count = refs[idx];
			end else begin
				// release to zero or destroy
				kill_slot(idx);
				r.destroyed = 1'b1;
			end
			r.generation = gens[idx];
		end
		r.live_count = CNT_W'(live);
		resp_q = {resp_q, r};
	endtask

	assign pending = resp_q.size();

	always @(posedge clk or negedge arst_n) begin
		result_t exp_r, got;
		if (!arst_n) begin
			free_top = 0;
			issued = 0;
			live = 0;
			err_count = 0;
			resp_q.delete();
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.status, out_ch.out_index, out_ch.out_generation,
					out_ch.ref_count, out_ch.destroyed, out_ch.live_count};
				if (resp_q.size() == 0) begin
					$display("%0t: unexpected transaction, actual %h", $realtime, got);
					err_count++;
				end else begin
					exp_r = resp_q.pop_front();
					if (got !== exp_r) begin
						$display("%0t: mismatch expected st=%0d idx=%0d gen=%h ref=%0d dead=%0d live=%0d",
							$realtime, exp_r.status, exp_r.index, exp_r.generation,
							exp_r.ref_count, exp_r.destroyed, exp_r.live_count);
						$display("%0t:          actual   st=%0d idx=%0d gen=%h ref=%0d dead=%0d live=%0d",
							$realtime, got.status, got.index, got.generation,
							got.ref_count, got.destroyed, got.live_count);
						err_count++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				predict_op(in_ch.mode, in_ch.slot_index, in_ch.slot_generation);
		end
	end
endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the generational handle table: directed corner
// cases, then random create/ref/destroy traffic with bursty requests,
// response stalls, a long response hold-off and a drain pause
// ----------------------------------------------------------------------------
module tb
	import ght_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	int   err_count, pending;
	int   cycles;
	bit   hold_off;

	ght_in_if  in_ch();
	ght_out_if out_ch();

	generational_handle_table dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));
	ght_checker chk (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.err_count(err_count), .pending(pending));

	// handles this side believes are live, used to aim ref traffic
	logic [7:0]  live_idx[$];
	logic [31:0] live_gen[$];

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	// receiver: own stall pattern, plus one long hold-off
	initial begin
		int n;
		bit held;
		held = 0;
		out_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off && !held) begin
				out_ch.ready <= 0;
				held = 1;
				repeat (300) @(posedge clk);
			end
			n = $urandom_range(0, 9);
			if (n < 3) out_ch.ready <= (cycles % 7) < 4;
			else if (n < 5) out_ch.ready <= 0;
			else out_ch.ready <= 1;
		end
	end

	// one transaction; idle gaps between bursts handled by caller
	task automatic send(logic [2:0] m, logic [7:0] idx, logic [31:0] g);
		in_ch.valid           <= 1;
		in_ch.mode            <= m;
		in_ch.slot_index      <= idx;
		in_ch.slot_generation <= g;
		in_ch.offset_x        <= $urandom;
		in_ch.offset_y        <= $urandom;
		in_ch.offset_z        <= $urandom;
		in_ch.extent_x        <= $urandom;
		in_ch.extent_y        <= $urandom;
		in_ch.extent_z        <= $urandom;
		in_ch.sphere_radius   <= $urandom;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic idle(int n);
		in_ch.valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// pick a random operation aimed mostly at live handles, track result in
	// the local list only roughly; the checker holds the exact truth
	task automatic random_op();
		int  k, r;
		logic [2:0] m;
		r = $urandom_range(0, 99);
		if (live_idx.size() == 0 || r < 25) begin
			m = $urandom_range(0, 1) ? MODE_SPHERE : MODE_BOX;
			send(m, 8'($urandom), $urandom);
		end else if (r < 92) begin
			k = $urandom_range(0, live_idx.size() - 1);
			m = (r < 55) ? MODE_ADD : (r < 80) ? MODE_RELEASE : MODE_DESTROY;
			send(m, live_idx[k], live_gen[k]);
		end else if (r < 97) begin
			// stale or wrong generation
			k = $urandom_range(0, live_idx.size() - 1);
			send(3'($urandom_range(2, 4)), live_idx[k],
				live_gen[k] ^ (32'd1 << $urandom_range(0, 31)));
		end else begin
			send(3'($urandom_range(5, 7)), 8'($urandom), $urandom);
		end
	endtask

	// re-learn live handles from response traffic
	always @(posedge clk) begin
		int i;
		if (arst_n && out_ch.valid && out_ch.ready && out_ch.status == ST_DONE) begin
			for (i = 0; i < live_idx.size(); i++)
				if (live_idx[i] == out_ch.out_index) begin
					live_idx.delete(i);
					live_gen.delete(i);
					break;
				end
			if (!out_ch.destroyed) begin
				live_idx = {live_idx, out_ch.out_index};
				live_gen = {live_gen, out_ch.out_generation};
			end
		end
	end

	initial begin
		int i, b;
		hold_off = 0;
		arst_n = 0;
		in_ch.valid = 0;
		in_ch.mode = MODE_BOX;
		in_ch.slot_index = 0;
		in_ch.slot_generation = 0;
		in_ch.offset_x = 0;
		in_ch.offset_y = 0;
		in_ch.offset_z = 0;
		in_ch.extent_x = 0;
		in_ch.extent_y = 0;
		in_ch.extent_z = 0;
		in_ch.sphere_radius = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: ops on an empty table, unknown modes
		send(MODE_ADD, 8'd0, 32'd0);
		send(MODE_RELEASE, 8'hFF, 32'hFFFFFFFF);
		send(MODE_DESTROY, 8'd0, 32'd0);
		send(3'd5, 8'd0, 32'd0);
		send(3'd7, 8'hFF, 32'hFFFFFFFF);
		// create, release at zero, add, release to zero destroys
		send(MODE_BOX, 8'd0, 32'd0);
		send(MODE_SPHERE, 8'd0, 32'd0);
		send(MODE_RELEASE, 8'd0, 32'd0);
		send(MODE_ADD, 8'd0, 32'd0);
		send(MODE_ADD, 8'd0, 32'd0);
		send(MODE_RELEASE, 8'd0, 32'd0);
		send(MODE_RELEASE, 8'd0, 32'd0);
		// stale handle after destroy, then reuse; destroy and reuse each bump the generation
		send(MODE_ADD, 8'd0, 32'd0);
		send(MODE_BOX, 8'd0, 32'd0);
		send(MODE_ADD, 8'd0, 32'd2);
		// destroy slot 0 so the last record moves into the hole
		send(MODE_BOX, 8'd0, 32'd0);
		send(MODE_DESTROY, 8'd0, 32'd2);
		send(MODE_ADD, 8'd1, 32'd0);
		drain();

		// fill the table to full, then overflow
		for (i = 0; i < 258; i++) send(3'($urandom_range(0, 1)), 8'($urandom), $urandom);
		drain();
		// a few references on one live handle, then one release
		for (i = 0; i < 4; i++) send(MODE_ADD, live_idx[0], live_gen[0]);
		send(MODE_RELEASE, live_idx[0], live_gen[0]);
		drain();
		// empty most of the table through destroy
		while (live_idx.size() > 3) begin
			send(MODE_DESTROY, live_idx[0], live_gen[0]);
			drain();
		end

		// random traffic in bursts; long response hold-off once
		for (i = 0; i < 1350; ) begin
			b = $urandom_range(1, 20);
			repeat (b) begin
				random_op();
				i++;
				if (i == 600) hold_off = 1;
			end
			if (i > 1000 && i < 1021) drain();
			else if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 12));
		end

		in_ch.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule

>>> generational_handle_table.f
rtl/core/ght_pkg.sv
rtl/core/ght_in_if.sv
rtl/core/ght_out_if.sv
rtl/core/ght_ram.sv
rtl/core/ght_ctrl.sv
rtl/core/ght_dp.sv
rtl/core/generational_handle_table.sv
verif/ght_checker.sv
verif/tb.sv
